// File: rtl/core/rcms_pkg.sv
// Shared constants, types and controller/datapath handshake structs for the
// region colour mean/std range core. No dependencies.
`timescale 1ns / 1ps

package rcms_pkg;

  // Region bound and pixel format
  localparam int MAX_PIXELS = 1024;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = 8;

  // Derived widths
  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W  = $clog2(MAX_PIXELS * 255 + 1);
  localparam int DEV_W  = $clog2(longint'(MAX_PIXELS) * 65025 + 1);
  localparam int VAR_W  = 2 * PIX_W;
  localparam int SD_W   = PIX_W;
  localparam int RES_W  = PIX_W + 1;
  localparam int CH_W   = 2;

  // Stream word widths
  localparam int IN_DATA_W  = NUM_CH * PIX_W;
  localparam int OUT_BITS   = NUM_CH * 2 * RES_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [CH_W-1:0] chan_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load;
    logic  div_start;
    logic  div_var;
    logic  scan_start;
    logic  sqrt_start;
    logic  out_load;
    chan_t chan;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic sqrt_done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/rcms_div.sv
// Restoring divider, one quotient bit a cycle, shared for the means and the
// variances. Depends on rcms_pkg.
`timescale 1ns / 1ps

module rcms_div
  import rcms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEV_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [DEV_W-1:0] quotient,
  output logic             done
);

  localparam int STEP_W = (DEV_W > 1) ? $clog2(DEV_W) : 1;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [DEV_W-1:0]  quo;
  logic [CNT_W-1:0]  dsor;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              ge;

  // Trial subtract of the divisor from the shifted remainder
  assign shifted = {rem, quo[DEV_W-1]};
  assign diff    = shifted - {1'b0, dsor};
  assign ge      = ~diff[CNT_W];

  // Control: busy for DEV_W steps, done pulse after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: latch operands, then shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dsor <= divisor;
      step <= STEP_W'(DEV_W - 1);
    end else if (busy) begin
      rem  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo  <= {quo[DEV_W-2:0], ge};
      step <= step - 1'b1;
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/core/rcms_ctrl.sv
// Sequencer for the region core: pixel load, means, deviation scan,
// variance division, square root and result hand-off. Depends on rcms_pkg.
`timescale 1ns / 1ps

module rcms_ctrl
  import rcms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_LOAD      = 10'b00_0000_0001,
    S_MEAN_GO   = 10'b00_0000_0010,
    S_MEAN_WAIT = 10'b00_0000_0100,
    S_SCAN_GO   = 10'b00_0000_1000,
    S_SCAN_WAIT = 10'b00_0001_0000,
    S_VAR_GO    = 10'b00_0010_0000,
    S_VAR_WAIT  = 10'b00_0100_0000,
    S_SQRT_GO   = 10'b00_1000_0000,
    S_SQRT_WAIT = 10'b01_0000_0000,
    S_DONE      = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  chan_t  chan, chan_next;
  logic   last_chan;

  assign last_chan = (chan == CH_W'(NUM_CH - 1));

  // State and channel registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      chan  <= '0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next     = state;
    chan_next      = chan;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.chan       = chan;
    cmd.div_var    = state inside {S_VAR_GO, S_VAR_WAIT};
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          state_next = S_MEAN_GO;
          chan_next  = '0;
        end
      end
      S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (status.div_done) begin
          if (last_chan) begin
            state_next = S_SCAN_GO;
          end else begin
            chan_next  = chan + 1'b1;
            state_next = S_MEAN_GO;
          end
        end
      end
      S_SCAN_GO: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (status.scan_done) begin
          chan_next  = '0;
          state_next = S_VAR_GO;
        end
      end
      S_VAR_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        if (status.div_done) begin
          state_next = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (status.sqrt_done) begin
          if (last_chan) begin
            state_next = S_DONE;
          end else begin
            chan_next  = chan + 1'b1;
            state_next = S_VAR_GO;
          end
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

// File: rtl/core/rcms_datapath.sv
// Datapath of the region core: pixel store, channel sums, deviation scan,
// square root and result register. Depends on rcms_pkg and rcms_div.
`timescale 1ns / 1ps

module rcms_datapath
  import rcms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [IN_DATA_W-1:0]  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int BIT_W = (SD_W > 1) ? $clog2(SD_W) : 1;

  // Pixel store and region accumulators
  logic [IN_DATA_W-1:0] mem [MAX_PIXELS];
  logic [CNT_W-1:0]     count;
  logic [SUM_W-1:0]     sums [NUM_CH];
  logic                 full;

  // Per-channel results
  logic [PIX_W-1:0] mean [NUM_CH];
  logic [SD_W-1:0]  sd   [NUM_CH];
  logic [DEV_W-1:0] dev  [NUM_CH];
  logic [VAR_W-1:0] sq   [NUM_CH];
  logic [VAR_W-1:0] variance;

  // Scan pipeline
  logic [CNT_W-1:0]     scan_addr;
  logic                 scan_active;
  logic                 scan_issue;
  logic                 rd_valid;
  logic                 sq_valid;
  logic [IN_DATA_W-1:0] rd_data;
  logic                 scan_done;

  // Divider hook-up
  logic [DEV_W-1:0] div_dividend;
  logic [DEV_W-1:0] div_quotient;
  logic             div_done;

  // Square root
  logic [SD_W-1:0]  root;
  logic [SD_W-1:0]  root_next;
  logic [SD_W-1:0]  trial;
  logic [VAR_W-1:0] trial_sq;
  logic [BIT_W-1:0] root_bit;
  logic             sqrt_active;
  logic             sqrt_done;

  logic [OUT_DATA_W-1:0] out_word;

  assign full = (count == CNT_W'(MAX_PIXELS));

  // Count and sums: take the pixel while room is left, clear on hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int c = 0; c < NUM_CH; c++) sums[c] <= '0;
    end else if (cmd.out_load) begin
      count <= '0;
      for (int c = 0; c < NUM_CH; c++) sums[c] <= '0;
    end else if (cmd.load && !full) begin
      count <= count + 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        sums[c] <= sums[c] + SUM_W'(in_data[c*PIX_W +: PIX_W]);
      end
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[ADDR_W-1:0]] <= in_data;
    end
    rd_data <= mem[scan_addr[ADDR_W-1:0]];
  end

  // Scan control: issue one address a cycle until count is reached
  assign scan_issue = scan_active && (scan_addr != count);
  assign scan_done  = scan_active && !scan_issue && !rd_valid && !sq_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      rd_valid    <= 1'b0;
      sq_valid    <= 1'b0;
    end else begin
      rd_valid <= scan_issue;
      sq_valid <= rd_valid;
      if (cmd.scan_start) begin
        scan_active <= 1'b1;
      end else if (scan_done) begin
        scan_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (scan_issue) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  // Square each deviation, then accumulate
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      logic [PIX_W-1:0] v;
      logic [PIX_W-1:0] d;
      v = rd_data[c*PIX_W +: PIX_W];
      d = (v > mean[c]) ? (v - mean[c]) : (mean[c] - v);
      sq[c] <= d * d;
      if (cmd.scan_start) begin
        dev[c] <= '0;
      end else if (sq_valid) begin
        dev[c] <= dev[c] + DEV_W'(sq[c]);
      end
    end
  end

  // Shared divider: sums for the means, deviations for the variances
  assign div_dividend = cmd.div_var ? dev[cmd.chan] : DEV_W'(sums[cmd.chan]);

  rcms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .quotient (div_quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      if (cmd.div_var) begin
        variance <= div_quotient[VAR_W-1:0];
      end else begin
        mean[cmd.chan] <= div_quotient[PIX_W-1:0];
      end
    end
  end

  // Floor square root, one result bit a cycle from the top
  assign trial     = root | (SD_W'(1) << root_bit);
  assign trial_sq  = trial * trial;
  assign root_next = (trial_sq <= variance) ? trial : root;

  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_active <= 1'b0;
      sqrt_done   <= 1'b0;
    end else begin
      sqrt_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sqrt_active <= 1'b1;
      end else if (sqrt_active && root_bit == '0) begin
        sqrt_active <= 1'b0;
        sqrt_done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      root     <= '0;
      root_bit <= BIT_W'(SD_W - 1);
    end else if (sqrt_active) begin
      root     <= root_next;
      root_bit <= root_bit - 1'b1;
      if (root_bit == '0) begin
        sd[cmd.chan] <= root_next;
      end
    end
  end

  // Pack mean - std and mean + std per channel
  always_comb begin
    out_word = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      out_word[2*c*RES_W +: RES_W]       = {1'b0, mean[c]} - {1'b0, sd[c]};
      out_word[(2*c+1)*RES_W +: RES_W]   = {1'b0, mean[c]} + {1'b0, sd[c]};
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= out_word;
    end
  end

  assign status.div_done  = div_done;
  assign status.scan_done = scan_done;
  assign status.sqrt_done = sqrt_done;
  assign status.out_free  = !out_valid || out_ready;

endmodule

// File: rtl/core/region_color_mean_std_range_core.sv
// Top level of the region colour mean/std range core: joins the controller
// and the datapath. Depends on rcms_pkg, rcms_ctrl and rcms_datapath.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   s_axis_tdata (pixel), s_axis_tlast
//   m_axis    out  m_axis_tvalid/m_axis_tready   m_axis_tdata (six range bounds)
//
// Pixels are taken one a cycle while a region loads. After the item marked
// tlast, s_axis_tready stays low through three mean divisions, a scan of the
// store, then per channel a variance division and a square root, and one
// hand-off. Reset clears the count, the sums and all control state; not the
// store. The hand-off waits only while the previous result is still untaken.
`timescale 1ns / 1ps

module region_color_mean_std_range_core
  import rcms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] chan0_value, [15:8] chan1_value, [23:16] chan2_value
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // last_pixel
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [8:0] chan0_low, [17:9] chan0_high, [26:18] chan1_low,
  // [35:27] chan1_high, [44:36] chan2_low, [53:45] chan2_high, [55:54] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  rcms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, arithmetic and result register
  rcms_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: rtl/core/rcms_checker.sv
// Port-level checks for the region core, bound to the top level.
// Depends on rcms_pkg and region_color_mean_std_range_core.
`timescale 1ns / 1ps

module rcms_checker
  import rcms_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Reset empties the output
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Stop taking pixels once a region is closed
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("pixel input still ready after last pixel");

  // A new result only appears after the compute phase
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while loading");

  // Low and high differ by twice the std, so share their lowest bit
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == m_axis_tdata[9]) &&
                      (m_axis_tdata[18] == m_axis_tdata[27]) &&
                      (m_axis_tdata[36] == m_axis_tdata[45]))
    else $error("range bounds not symmetric about the mean");

endmodule

bind region_color_mean_std_range_core rcms_checker u_rcms_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
